### rtl/lph_pkg.sv
// Shared constants, codes and control/status types of the linear probing hash set.
`timescale 1ns / 1ps
`default_nettype none
package lph_pkg;
	localparam int SLOT_COUNT_DEF = 1024;
	localparam int KEY_W = 64;
	localparam int LIVE_W = 11;

	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int MIX_SHIFT = 33;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic [1:0] ADDR_POS  = 2'd0;
	localparam logic [1:0] ADDR_HOLE = 2'd1;
	localparam logic [1:0] ADDR_CLR  = 2'd2;

	localparam logic [1:0] WD_ZERO = 2'd0;
	localparam logic [1:0] WD_KEY  = 2'd1;
	localparam logic [1:0] WD_CAND = 2'd2;

	typedef struct packed {
		logic       load_item;
		logic       hash_start;
		logic       hash_sel;
		logic       pos_home;
		logic       pos_inc;
		logic       hole_load;
		logic       mem_rd;
		logic       mem_wr;
		logic [1:0] addr_sel;
		logic [1:0] wd_sel;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       clr_inc;
		logic       res_load;
		logic       res_present;
		logic [1:0] res_status;
	} lph_cmd_t;

	typedef struct packed {
		logic       key_zero;
		logic [1:0] op;
		logic       hash_done;
		logic       rd_zero;
		logic       rd_match;
		logic       stay;
		logic       at_limit;
		logic       clr_last;
	} lph_sts_t;
endpackage
`default_nettype wire

### rtl/lph_hash.sv
// Iterative 64-bit Murmur finalizer built on one shared 32x32 multiplier.
`timescale 1ns / 1ps
`default_nettype none
module lph_hash
	import lph_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [KEY_W-1:0] key_in,
	output logic                  done,
	output logic [KEY_W-1:0]      hash
);
	logic [63:0] h_q;
	logic [63:0] acc_q;
	logic [1:0]  ph_q;
	logic        round_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] prod;
	logic [63:0] cst;

	always_comb begin
		cst  = round_q ? MIX_C2 : MIX_C1;
		ma   = (ph_q == 2'd1) ? h_q[63:32] : h_q[31:0];
		mb   = (ph_q == 2'd2) ? cst[63:32] : cst[31:0];
		prod = {32'd0, ma} * {32'd0, mb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			ph_q    <= 2'd0;
			round_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				ph_q    <= 2'd0;
				round_q <= 1'b0;
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) begin
					round_q <= 1'b1;
					if (round_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= key_in ^ (key_in >> MIX_SHIFT);
		end else if (busy_q) begin
			case (ph_q)
				2'd0: acc_q <= prod;
				2'd1, 2'd2: acc_q <= acc_q + {prod[31:0], 32'd0};
				default: h_q <= acc_q ^ (acc_q >> MIX_SHIFT);
			endcase
		end
	end

	assign done = done_q;
	assign hash = h_q;
endmodule
`default_nettype wire

### rtl/lph_datapath.sv
// Slot memory, probe registers, key count and result registers of the hash set.
`timescale 1ns / 1ps
`default_nettype none
module lph_datapath
	import lph_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lph_cmd_t         cmd,
	output lph_sts_t              sts,
	input  wire logic [1:0]       op,
	input  wire logic [KEY_W-1:0] key,
	output logic                  was_present,
	output logic [1:0]            status,
	output logic [LIVE_W-1:0]     live_count
);
	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT / 2 + 1);

	logic [KEY_W-1:0] mem [SLOT_COUNT];
	logic [KEY_W-1:0] rdata_q;
	logic [KEY_W-1:0] key_q;
	logic [1:0]       op_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] hole_q;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] addr;
	logic [KEY_W-1:0] wdata;
	logic [KEY_W-1:0] hash_in;
	logic [KEY_W-1:0] hash;
	logic             hash_done;
	logic [IDX_W-1:0] home;
	logic [IDX_W-1:0] d_home;
	logic [IDX_W-1:0] d_hole;
	logic [CNT_W+LIVE_W-1:0] cnt_ext;

	assign hash_in = cmd.hash_sel ? rdata_q : key_q;

	lph_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.hash_start),
		.key_in (hash_in),
		.done   (hash_done),
		.hash   (hash)
	);

	always_comb begin
		home   = hash[IDX_W-1:0];
		d_home = pos_q - home;
		d_hole = pos_q - hole_q;
		case (cmd.addr_sel)
			ADDR_POS:  addr = pos_q;
			ADDR_HOLE: addr = hole_q;
			default:   addr = clr_q;
		endcase
		case (cmd.wd_sel)
			WD_KEY:  wdata = key_q;
			WD_CAND: wdata = rdata_q;
			default: wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q <= key;
			op_q  <= op;
		end
		if (cmd.pos_home) begin
			pos_q <= home;
		end else if (cmd.pos_inc) begin
			pos_q <= pos_q + IDX_W'(1);
		end
		if (cmd.hole_load) begin
			hole_q <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			was_present <= 1'b0;
			status      <= ST_DONE;
			live_count  <= '0;
		end else begin
			if (cmd.clr_inc) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec && cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.res_load) begin
				was_present <= cmd.res_present;
				status      <= cmd.res_status;
				live_count  <= cnt_ext[LIVE_W-1:0];
			end
		end
	end

	assign cnt_ext = {{LIVE_W{1'b0}}, cnt_q};

	always_comb begin
		sts.key_zero  = (key_q == '0);
		sts.op        = op_q;
		sts.hash_done = hash_done;
		sts.rd_zero   = (rdata_q == '0);
		sts.rd_match  = (rdata_q == key_q);
		sts.stay      = (d_home < d_hole);
		sts.at_limit  = (cnt_q >= CNT_W'(SLOT_COUNT / 2));
		sts.clr_last  = (clr_q == {IDX_W{1'b1}});
	end
endmodule
`default_nettype wire

### rtl/lph_ctrl.sv
// Controller state machine: clearing pass, probe walk, insert and backward-shift erase.
`timescale 1ns / 1ps
`default_nettype none
module lph_ctrl
	import lph_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire lph_sts_t sts,
	output lph_cmd_t      cmd
);
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_START = 4'd2;
	localparam logic [3:0] S_HASH  = 4'd3;
	localparam logic [3:0] S_PRD   = 4'd4;
	localparam logic [3:0] S_PCMP  = 4'd5;
	localparam logic [3:0] S_EINC  = 4'd6;
	localparam logic [3:0] S_ERD   = 4'd7;
	localparam logic [3:0] S_ECMP  = 4'd8;
	localparam logic [3:0] S_EHASH = 4'd9;
	localparam logic [3:0] S_MV1   = 4'd10;
	localparam logic [3:0] S_MV2   = 4'd11;
	localparam logic [3:0] S_RES   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       present_q;
	logic       present_d;
	logic [1:0] status_q;
	logic [1:0] status_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		present_d = present_q;
		status_d  = status_q;
		case (state_q)
			S_CLEAR: begin
				cmd.mem_wr   = 1'b1;
				cmd.addr_sel = ADDR_CLR;
				cmd.wd_sel   = WD_ZERO;
				cmd.clr_inc  = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_START;
				end
			end
			S_START: begin
				present_d = 1'b0;
				if (sts.key_zero) begin
					status_d = ST_ZERO;
					state_d  = S_RES;
				end else begin
					status_d       = ST_DONE;
					cmd.hash_start = 1'b1;
					state_d        = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.hash_done) begin
					cmd.pos_home = 1'b1;
					state_d      = S_PRD;
				end
			end
			S_PRD: begin
				cmd.mem_rd   = 1'b1;
				cmd.addr_sel = ADDR_POS;
				state_d      = S_PCMP;
			end
			S_PCMP: begin
				if (!sts.rd_zero && !sts.rd_match) begin
					cmd.pos_inc = 1'b1;
					state_d     = S_PRD;
				end else begin
					present_d = sts.rd_match;
					state_d   = S_RES;
					if (sts.op == OP_ADD && !sts.rd_match) begin
						if (sts.at_limit) begin
							status_d = ST_FULL;
						end else begin
							cmd.mem_wr   = 1'b1;
							cmd.addr_sel = ADDR_POS;
							cmd.wd_sel   = WD_KEY;
							cmd.cnt_inc  = 1'b1;
						end
					end else if (sts.op == OP_REMOVE && sts.rd_match) begin
						cmd.mem_wr    = 1'b1;
						cmd.addr_sel  = ADDR_POS;
						cmd.wd_sel    = WD_ZERO;
						cmd.hole_load = 1'b1;
						cmd.cnt_dec   = 1'b1;
						state_d       = S_EINC;
					end
				end
			end
			S_EINC: begin
				cmd.pos_inc = 1'b1;
				state_d     = S_ERD;
			end
			S_ERD: begin
				cmd.mem_rd   = 1'b1;
				cmd.addr_sel = ADDR_POS;
				state_d      = S_ECMP;
			end
			S_ECMP: begin
				if (sts.rd_zero) begin
					state_d = S_RES;
				end else begin
					cmd.hash_start = 1'b1;
					cmd.hash_sel   = 1'b1;
					state_d        = S_EHASH;
				end
			end
			S_EHASH: begin
				if (sts.hash_done) begin
					state_d = sts.stay ? S_EINC : S_MV1;
				end
			end
			S_MV1: begin
				cmd.mem_wr   = 1'b1;
				cmd.addr_sel = ADDR_HOLE;
				cmd.wd_sel   = WD_CAND;
				state_d      = S_MV2;
			end
			S_MV2: begin
				cmd.mem_wr    = 1'b1;
				cmd.addr_sel  = ADDR_POS;
				cmd.wd_sel    = WD_ZERO;
				cmd.hole_load = 1'b1;
				state_d       = S_EINC;
			end
			S_RES: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load    = 1'b1;
					cmd.res_present = present_q;
					cmd.res_status  = status_q;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			present_q   <= 1'b0;
			status_q    <= ST_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			present_q <= present_d;
			status_q  <= status_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !cmd.mem_wr)
		else $error("slot memory written while idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_hash_owner: assert property (@(posedge clk) disable iff (!arst_n)
		sts.hash_done |-> (state_q == S_HASH || state_q == S_EHASH))
		else $error("hash finished outside a waiting state");

	a_hash_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hash_start |=> (state_q == S_HASH || state_q == S_EHASH))
		else $error("hash started without waiting for it");
endmodule
`default_nettype wire

### rtl/linear_probe_hash_set.sv
// Top level of the linear probing hash set of nonzero 64-bit keys.
//
// Input channel in_valid/in_ready carries one item: op (add, remove, test) and key.
// Output channel out_valid/out_ready returns one result per item: was_present,
// status and live_count. Items are handled one at a time; the next item is
// accepted as soon as the previous result sits in the output register.
// Each item is accepted and started; a nonzero key is hashed by the Murmur
// finalizer on the single 32x32 multiplier and probed slot by slot on the
// single-port slot memory (a read, then a compare, per probed slot); the
// result then goes to the output register. A removal also walks the shift
// chain, rehashing each key inspected, and moves a key back by writing it
// into the hole and zeroing its old slot. After reset the block runs a
// clearing pass, zeroing every slot, with in_ready low. When the receiver
// stalls, the result waits in the output register; one further item is
// processed and then waits in turn until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_set
	import lph_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       op,
	input  wire logic [KEY_W-1:0] key,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  was_present,
	output logic [1:0]            status,
	output logic [LIVE_W-1:0]     live_count
);
	lph_cmd_t cmd;
	lph_sts_t sts;

	lph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lph_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.key         (key),
		.was_present (was_present),
		.status      (status),
		.live_count  (live_count)
	);
endmodule
`default_nettype wire
